// ===== rtl/bqc_pkg.sv =====
package bqc_pkg;

	localparam int ACC_W   = 32;
	localparam int SMP_W   = 16;
	localparam int COEF_W  = 16;
	localparam int GAIN_W  = 15;
	localparam int MPL_W   = 16;
	localparam int CNT_W   = 4;
	localparam int IDX_W   = 3;
	localparam int NUM_MUL = 8;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPL_W - 1);

	// register indexes of the configuration channel
	localparam logic [IDX_W-1:0] REG_S1_FF   = 3'd0;
	localparam logic [IDX_W-1:0] REG_S1_FB   = 3'd1;
	localparam logic [IDX_W-1:0] REG_S2_FF   = 3'd2;
	localparam logic [IDX_W-1:0] REG_S2_FB   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_1  = 3'd4;
	localparam logic [IDX_W-1:0] REG_GAIN_2  = 3'd5;

	localparam logic [ACC_W-1:0]  RST_S1_FF  = 32'h4000_7FFF;
	localparam logic [ACC_W-1:0]  RST_S1_FB  = 32'hC617_78DE;
	localparam logic [ACC_W-1:0]  RST_S2_FF  = 32'h4000_7FFF;
	localparam logic [ACC_W-1:0]  RST_S2_FB  = 32'hCDC6_7140;
	localparam logic [GAIN_W-1:0] RST_GAIN_1 = 15'd67;
	localparam logic [GAIN_W-1:0] RST_GAIN_2 = 15'd63;

	typedef struct packed {
		logic [ACC_W-1:0]  s1_ff;
		logic [ACC_W-1:0]  s1_fb;
		logic [ACC_W-1:0]  s2_ff;
		logic [ACC_W-1:0]  s2_fb;
		logic [GAIN_W-1:0] gain_1;
		logic [GAIN_W-1:0] gain_2;
	} cfg_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MUL1 = 8'b0000_0010,
		S_SUM  = 8'b0000_0100,
		S_TOT  = 8'b0000_1000,
		S_SEC1 = 8'b0001_0000,
		S_MUL2 = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_SPARE = 8'b1000_0000
	} state_t;

endpackage

// ===== rtl/bqc_serial_mul.sv =====
module bqc_serial_mul import bqc_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic             msb,
	input  logic [ACC_W-1:0] mcand,
	input  logic [MPL_W-1:0] mplier,
	output logic [ACC_W-1:0] product
);

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] mc_q;
	logic [MPL_W-1:0] mp_q;

	// one multiplier bit per cycle while step is high, LSB first; the top bit carries negative weight
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= '0;
			mc_q  <= mcand;
			mp_q  <= mplier;
		end else if (step) begin
			if (mp_q[0]) begin
				acc_q <= msb ? (acc_q - mc_q) : (acc_q + mc_q);
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign product = acc_q;

endmodule

// ===== rtl/bqc_cfg_regs.sv =====
module bqc_cfg_regs import bqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [ACC_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.s1_ff  <= RST_S1_FF;
			cfg_q.s1_fb  <= RST_S1_FB;
			cfg_q.s2_ff  <= RST_S2_FF;
			cfg_q.s2_fb  <= RST_S2_FB;
			cfg_q.gain_1 <= RST_GAIN_1;
			cfg_q.gain_2 <= RST_GAIN_2;
		end else if (wr_en) begin
			case (wr_index)
				REG_S1_FF:  cfg_q.s1_ff  <= wr_data;
				REG_S1_FB:  cfg_q.s1_fb  <= wr_data;
				REG_S2_FF:  cfg_q.s2_ff  <= wr_data;
				REG_S2_FB:  cfg_q.s2_fb  <= wr_data;
				REG_GAIN_1: cfg_q.gain_1 <= wr_data[GAIN_W-1:0];
				REG_GAIN_2: cfg_q.gain_2 <= wr_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/biquad_cascade_audio_filter.sv =====
// Channel  Signals                         Payload (low bit up)
// s        s_tvalid s_tready s_tdata s_tlast   audio_sample[15:0]; end_of_block
// m        m_tvalid m_tready m_tdata m_tlast   filtered_sample, raw_copy; last_out
// cfg      cfg_valid cfg_ready cfg_index cfg_data  register index, 32-bit value
//
// Each sample runs two passes of bit-serial shift-add multipliers (delay products
// with the section one gain, then the section two gain) and the add/control states
// SUM, TOT, SEC1 and FIN; a new sample is accepted only once back in idle.
// Reset clears the delays, loads the default coefficients and empties the output.
// A finished beat waits in the output register; only the hand-off of the next
// result stalls, while that beat is still waiting and m_tready is low.
module biquad_cascade_audio_filter import bqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,    // [15:0] audio_sample
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,    // [15:0] filtered_sample, [31:16] raw_copy
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [ACC_W-1:0] cfg_data
);

	cfg_t             cfg;
	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic [SMP_W-1:0] d0_q, d1_q, d2_q, d3_q;
	logic [SMP_W-1:0] sample_q;
	logic             last_q;
	logic [ACC_W-1:0] fb1_q, ff1_q, fb2_q, ff2_q;
	logic [ACC_W-1:0] t1_q, t2_q;
	logic [SMP_W-1:0] w1_q;
	logic [31:0]      m_tdata_q;
	logic             m_tlast_q;

	logic                accept;
	logic                out_free;
	logic                mul_step;
	logic                mul_msb;
	logic [COEF_W-1:0]   coef   [NUM_MUL];
	logic [SMP_W-1:0]    dly    [NUM_MUL];
	logic [ACC_W-1:0]    prod   [NUM_MUL];
	logic                g_load;
	logic [ACC_W-1:0]    g_mcand;
	logic [MPL_W-1:0]    g_mplier;
	logic [ACC_W-1:0]    gprod;
	logic [ACC_W-1:0]    x1;
	logic [SMP_W-1:0]    w1_lo;
	logic [SMP_W-2:0]    x2_lo;
	logic [SMP_W-1:0]    w2_lo;

	assign cfg_ready = 1'b1;

	bqc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign mul_step = (state_q == S_MUL1) || (state_q == S_MUL2);
	assign mul_msb  = (cnt_q == CNT_LAST);

	// feedback and feedforward products of both sections, all on the old delays
	assign coef[0] = cfg.s1_fb[15:0];   assign dly[0] = d0_q;
	assign coef[1] = cfg.s1_fb[31:16];  assign dly[1] = d1_q;
	assign coef[2] = cfg.s1_ff[15:0];   assign dly[2] = d0_q;
	assign coef[3] = cfg.s1_ff[31:16];  assign dly[3] = d1_q;
	assign coef[4] = cfg.s2_fb[15:0];   assign dly[4] = d2_q;
	assign coef[5] = cfg.s2_fb[31:16];  assign dly[5] = d3_q;
	assign coef[6] = cfg.s2_ff[15:0];   assign dly[6] = d2_q;
	assign coef[7] = cfg.s2_ff[31:16];  assign dly[7] = d3_q;

	for (genvar k = 0; k < NUM_MUL; k++) begin : g_dmul
		bqc_serial_mul u_mul (
			.clk     (clk),
			.load    (accept),
			.step    (mul_step),
			.msb     (mul_msb),
			.mcand   ({{(ACC_W-COEF_W){coef[k][COEF_W-1]}}, coef[k]}),
			.mplier  (dly[k]),
			.product (prod[k])
		);
	end

	// gain multiplier: sample times gain one, later section one output times gain two
	assign x1 = {{15{gprod[31]}}, gprod[31:15]} + {{14{t1_q[31]}}, t1_q[31:14]};
	assign g_load   = accept || (state_q == S_SEC1);
	assign g_mcand  = (state_q == S_IDLE) ? {{(ACC_W-SMP_W){s_tdata[15]}}, s_tdata} : x1;
	assign g_mplier = (state_q == S_IDLE) ? {1'b0, cfg.gain_1} : {1'b0, cfg.gain_2};

	bqc_serial_mul u_gmul (
		.clk     (clk),
		.load    (g_load),
		.step    (mul_step),
		.msb     (mul_msb),
		.mcand   (g_mcand),
		.mplier  (g_mplier),
		.product (gprod)
	);

	// only the low bits of delays and output matter, so those adds stay narrow
	assign w1_lo = gprod[30:15] + fb1_q[29:14];
	assign w2_lo = gprod[29:14] + fb2_q[29:14];
	assign x2_lo = gprod[28:14] + t2_q[28:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			d0_q       <= '0;
			d1_q       <= '0;
			d2_q       <= '0;
			d3_q       <= '0;
		end else begin
			if (mul_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
				d1_q       <= d0_q;
				d0_q       <= w1_q;
				d3_q       <= d2_q;
				d2_q       <= w2_lo;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL1;
						cnt_q   <= '0;
					end
				end
				S_MUL1: begin
					if (mul_msb) state_q <= S_SUM;
				end
				S_SUM:  state_q <= S_TOT;
				S_TOT:  state_q <= S_SEC1;
				S_SEC1: state_q <= S_MUL2;
				S_MUL2: begin
					if (mul_msb) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata;
			last_q   <= s_tlast;
		end
		if (state_q == S_SUM) begin
			fb1_q <= prod[0] + prod[1];
			ff1_q <= prod[2] + prod[3];
			fb2_q <= prod[4] + prod[5];
			ff2_q <= prod[6] + prod[7];
		end
		if (state_q == S_TOT) begin
			t1_q <= fb1_q + ff1_q;
			t2_q <= fb2_q + ff2_q;
		end
		if (state_q == S_SEC1) begin
			w1_q <= w1_lo;
		end
		if (state_q == S_FIN && out_free) begin
			m_tdata_q <= {sample_q, x2_lo, 1'b0};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/bqc_checker.sv =====
module bqc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// one sample in flight: input closes right after a beat is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second input beat taken while busy");

	// input reopens only once the result sits in the output register
	a_reopen_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("input reopened without a result");

	// a result does not appear right after the sample that causes it
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result appeared too early");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind biquad_cascade_audio_filter bqc_checker u_bqc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
